### rtl/core/hc3_pkg.sv
// ----------------------------------------------------------------------------
// hc3_pkg: shared types and constants of the hermitian cofactor block
// Operand codes, item field layout, result widths and the per-row operand
// table used by the row datapath.
// ----------------------------------------------------------------------------
package hc3_pkg;

	// default input width (signed Q16.16)
	localparam int DATA_WIDTH_DEF = 32;

	// result format, signed Q32.32
	localparam int OUT_W = 64;
	localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// cofactor rows and columns
	localparam int NUM_ROWS  = 3;
	localparam int NUM_COLS  = 3;
	localparam int NUM_SLOTS = 4;
	localparam int ROW_W     = 2;
	localparam logic [ROW_W-1:0] ROW_0    = 2'd0;
	localparam logic [ROW_W-1:0] ROW_1    = 2'd1;
	localparam logic [ROW_W-1:0] ROW_2    = 2'd2;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_2;

	// item queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// field layout of a queued item, every field one bit wider than the input
	localparam int FLD_D0      = 0;
	localparam int FLD_D1      = 1;
	localparam int FLD_D2      = 2;
	localparam int FLD_XR      = 3;
	localparam int FLD_XI      = 4;
	localparam int FLD_YR      = 5;
	localparam int FLD_YI      = 6;
	localparam int FLD_ZR      = 7;
	localparam int FLD_ZI      = 8;
	localparam int ITEM_FIELDS = 9;

	// operand sources of one complex factor
	typedef enum logic [2:0] {
		SRC_D0 = 3'd0,
		SRC_D1 = 3'd1,
		SRC_D2 = 3'd2,
		SRC_X  = 3'd3,
		SRC_Y  = 3'd4,
		SRC_Z  = 3'd5
	} src_e_t;

	typedef struct packed {
		src_e_t src;
		logic   conj;
	} opnd_t;

	// entry = p1*q1 - p2*q2, slots in the order p1, q1, p2, q2
	localparam opnd_t OPND_TBL [NUM_ROWS][NUM_COLS][NUM_SLOTS] = '{
		'{
			'{'{SRC_D1, 1'b0}, '{SRC_D2, 1'b0}, '{SRC_Z, 1'b0}, '{SRC_Z, 1'b1}},
			'{'{SRC_Z, 1'b0}, '{SRC_Y, 1'b1}, '{SRC_X, 1'b1}, '{SRC_D2, 1'b0}},
			'{'{SRC_Z, 1'b1}, '{SRC_X, 1'b1}, '{SRC_Y, 1'b1}, '{SRC_D1, 1'b0}}
		},
		'{
			'{'{SRC_Y, 1'b0}, '{SRC_Z, 1'b1}, '{SRC_X, 1'b0}, '{SRC_D2, 1'b0}},
			'{'{SRC_D0, 1'b0}, '{SRC_D2, 1'b0}, '{SRC_Y, 1'b0}, '{SRC_Y, 1'b1}},
			'{'{SRC_Y, 1'b1}, '{SRC_X, 1'b0}, '{SRC_Z, 1'b1}, '{SRC_D0, 1'b0}}
		},
		'{
			'{'{SRC_X, 1'b0}, '{SRC_Z, 1'b0}, '{SRC_Y, 1'b0}, '{SRC_D1, 1'b0}},
			'{'{SRC_X, 1'b1}, '{SRC_Y, 1'b0}, '{SRC_Z, 1'b0}, '{SRC_D0, 1'b0}},
			'{'{SRC_D0, 1'b0}, '{SRC_D1, 1'b0}, '{SRC_X, 1'b0}, '{SRC_X, 1'b1}}
		}
	};

endpackage

### rtl/core/hermitian_cofactor_3x3_top.sv
// ----------------------------------------------------------------------------
// hermitian_cofactor_3x3_top: cofactor matrix of a shifted 3x3 hermitian matrix
// Front queue plus row datapath; one input item gives three result rows.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready, one item is the real diagonal, the three
//   complex upper entries and the shift eigen_value, all signed Q16.16
//   output channel: out_valid/out_ready, one item per cofactor row, row_index
//   0, 1, 2 in order, last_row set on row 2, entries signed Q32.32 saturated
//   row 0 passes the item queue and the product, pair-sum and output registers;
//   rows 1 and 2 follow on the next cycles when the receiver takes every row
//   throughput: one item per three cofactor rows, set by the single row datapath
//   (24 multipliers), one cofactor row per cycle while the receiver takes rows
//   a two-entry item queue lets new items be accepted while rows are in flight
//   receiver stall: the whole row pipeline holds, the queue fills, then
//   in_ready drops; nothing is lost
//   reset: queue empty, pipeline empty, row counter back to row 0
// ----------------------------------------------------------------------------
module hermitian_cofactor_3x3_top #(
	parameter int DATA_WIDTH = hc3_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [DATA_WIDTH-1:0]      diag_a,
	input  logic signed [DATA_WIDTH-1:0]      diag_b,
	input  logic signed [DATA_WIDTH-1:0]      diag_c,
	input  logic signed [DATA_WIDTH-1:0]      ab_real,
	input  logic signed [DATA_WIDTH-1:0]      ab_imag,
	input  logic signed [DATA_WIDTH-1:0]      ac_real,
	input  logic signed [DATA_WIDTH-1:0]      ac_imag,
	input  logic signed [DATA_WIDTH-1:0]      bc_real,
	input  logic signed [DATA_WIDTH-1:0]      bc_imag,
	input  logic signed [DATA_WIDTH-1:0]      eigen_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hc3_pkg::ROW_W-1:0]         row_index,
	output logic signed [hc3_pkg::OUT_W-1:0]  col0_real,
	output logic signed [hc3_pkg::OUT_W-1:0]  col0_imag,
	output logic signed [hc3_pkg::OUT_W-1:0]  col1_real,
	output logic signed [hc3_pkg::OUT_W-1:0]  col1_imag,
	output logic signed [hc3_pkg::OUT_W-1:0]  col2_real,
	output logic signed [hc3_pkg::OUT_W-1:0]  col2_imag,
	output logic                              last_row
);

	// queued item: shifted diagonal and upper entries, one bit of headroom each
	logic                                          q_valid;
	logic                                          q_ready;
	logic [hc3_pkg::ITEM_FIELDS-1:0][DATA_WIDTH:0] q_item;

	// one row of results, column-indexed
	logic [hc3_pkg::NUM_COLS-1:0][hc3_pkg::OUT_W-1:0] res_re;
	logic [hc3_pkg::NUM_COLS-1:0][hc3_pkg::OUT_W-1:0] res_im;

	// front: accept, form diagonal minus shift, queue
	hc3_front #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.diag_a      (diag_a),
		.diag_b      (diag_b),
		.diag_c      (diag_c),
		.ab_real     (ab_real),
		.ab_imag     (ab_imag),
		.ac_real     (ac_real),
		.ac_imag     (ac_imag),
		.bc_real     (bc_real),
		.bc_imag     (bc_imag),
		.eigen_value (eigen_value),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_item      (q_item)
	);

	// back: row sequencer, multiply, sum, saturate, output register
	hc3_back #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_index (row_index),
		.res_re    (res_re),
		.res_im    (res_im),
		.last_row  (last_row)
	);

	// column fan-out to the result ports
	assign col0_real = res_re[0];
	assign col0_imag = res_im[0];
	assign col1_real = res_re[1];
	assign col1_imag = res_im[1];
	assign col2_real = res_re[2];
	assign col2_imag = res_im[2];

endmodule

### rtl/core/hc3_front.sv
// ----------------------------------------------------------------------------
// hc3_front: input acceptance and item queue
// Takes one matrix item, forms the shifted diagonal and holds the item in a
// short queue until the row sequencer has issued all of its rows.
// ----------------------------------------------------------------------------
module hc3_front #(
	parameter int DATA_WIDTH = hc3_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] diag_a,
	input  logic signed [DATA_WIDTH-1:0] diag_b,
	input  logic signed [DATA_WIDTH-1:0] diag_c,
	input  logic signed [DATA_WIDTH-1:0] ab_real,
	input  logic signed [DATA_WIDTH-1:0] ab_imag,
	input  logic signed [DATA_WIDTH-1:0] ac_real,
	input  logic signed [DATA_WIDTH-1:0] ac_imag,
	input  logic signed [DATA_WIDTH-1:0] bc_real,
	input  logic signed [DATA_WIDTH-1:0] bc_imag,
	input  logic signed [DATA_WIDTH-1:0] eigen_value,
	output logic                         q_valid,
	input  logic                         q_ready,
	output logic [hc3_pkg::ITEM_FIELDS-1:0][DATA_WIDTH:0] q_item
);

	localparam int ITEM_W = DATA_WIDTH + 1;
	localparam int PTR_W  = (hc3_pkg::QUEUE_DEPTH > 1) ? $clog2(hc3_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(hc3_pkg::QUEUE_DEPTH + 1);

	logic [hc3_pkg::ITEM_FIELDS-1:0][ITEM_W-1:0] item_in;
	logic [hc3_pkg::ITEM_FIELDS-1:0][ITEM_W-1:0] mem_q [hc3_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	// shifted diagonal, one bit of growth
	always_comb begin
		item_in = '0;
		item_in[hc3_pkg::FLD_D0] = ITEM_W'(diag_a) - ITEM_W'(eigen_value);
		item_in[hc3_pkg::FLD_D1] = ITEM_W'(diag_b) - ITEM_W'(eigen_value);
		item_in[hc3_pkg::FLD_D2] = ITEM_W'(diag_c) - ITEM_W'(eigen_value);
		item_in[hc3_pkg::FLD_XR] = ITEM_W'(ab_real);
		item_in[hc3_pkg::FLD_XI] = ITEM_W'(ab_imag);
		item_in[hc3_pkg::FLD_YR] = ITEM_W'(ac_real);
		item_in[hc3_pkg::FLD_YI] = ITEM_W'(ac_imag);
		item_in[hc3_pkg::FLD_ZR] = ITEM_W'(bc_real);
		item_in[hc3_pkg::FLD_ZI] = ITEM_W'(bc_imag);
	end

	assign in_ready = (count_q != CNT_W'(hc3_pkg::QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(hc3_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(hc3_pkg::QUEUE_DEPTH))
		else $error("item queue over depth");

	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("item queue lost a push");

endmodule

### rtl/core/hc3_back.sv
// ----------------------------------------------------------------------------
// hc3_back: row sequencer and cofactor row datapath
// Issues the queued item's three rows, one per cycle unless the output stalls,
// through a multiply, pair-sum, final-sum/saturate pipeline ending in the output.
// ----------------------------------------------------------------------------
module hc3_back #(
	parameter int DATA_WIDTH = hc3_pkg::DATA_WIDTH_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           q_valid,
	output logic                                           q_ready,
	input  logic [hc3_pkg::ITEM_FIELDS-1:0][DATA_WIDTH:0]  q_item,
	output logic                                           out_valid,
	input  logic                                           out_ready,
	output logic [hc3_pkg::ROW_W-1:0]                      row_index,
	output logic [hc3_pkg::NUM_COLS-1:0][hc3_pkg::OUT_W-1:0] res_re,
	output logic [hc3_pkg::NUM_COLS-1:0][hc3_pkg::OUT_W-1:0] res_im,
	output logic                                           last_row
);

	localparam int ITEM_W = DATA_WIDTH + 1;
	localparam int PROD_W = 2 * ITEM_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int ACC_W  = (PAIR_W + 1 > hc3_pkg::OUT_W + 1) ? PAIR_W + 1 : hc3_pkg::OUT_W + 1;
	localparam int NPROD  = 8;

	logic                       adv;
	logic                       issue;
	logic [hc3_pkg::ROW_W-1:0]  row_q;

	logic signed [ITEM_W-1:0] op_re [hc3_pkg::NUM_COLS][hc3_pkg::NUM_SLOTS];
	logic signed [ITEM_W-1:0] op_im [hc3_pkg::NUM_COLS][hc3_pkg::NUM_SLOTS];

	logic                       valid_s1;
	logic [hc3_pkg::ROW_W-1:0]  row_s1;
	logic signed [PROD_W-1:0]   prod_s1 [hc3_pkg::NUM_COLS][NPROD];

	logic                       valid_s2;
	logic [hc3_pkg::ROW_W-1:0]  row_s2;
	logic signed [PAIR_W-1:0]   re_a_s2 [hc3_pkg::NUM_COLS];
	logic signed [PAIR_W-1:0]   re_b_s2 [hc3_pkg::NUM_COLS];
	logic signed [PAIR_W-1:0]   im_a_s2 [hc3_pkg::NUM_COLS];
	logic signed [PAIR_W-1:0]   im_b_s2 [hc3_pkg::NUM_COLS];

	logic signed [ACC_W-1:0]    re_sum [hc3_pkg::NUM_COLS];
	logic signed [ACC_W-1:0]    im_sum [hc3_pkg::NUM_COLS];

	logic                       valid_s3;
	logic [hc3_pkg::ROW_W-1:0]  row_s3;
	logic [hc3_pkg::NUM_COLS-1:0][hc3_pkg::OUT_W-1:0] re_s3;
	logic [hc3_pkg::NUM_COLS-1:0][hc3_pkg::OUT_W-1:0] im_s3;

	// whole pipeline moves unless the output stage holds a stalled row
	assign adv     = !valid_s3 || out_ready;
	assign issue   = q_valid && adv;
	assign q_ready = adv && (row_q == hc3_pkg::LAST_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= hc3_pkg::ROW_0;
		end else if (issue) begin
			row_q <= (row_q == hc3_pkg::LAST_ROW) ? hc3_pkg::ROW_0 : row_q + hc3_pkg::ROW_W'(1);
		end
	end

	// operand selection for the issued row
	always_comb begin
		hc3_pkg::opnd_t sel;
		for (int c = 0; c < hc3_pkg::NUM_COLS; c++) begin
			for (int s = 0; s < hc3_pkg::NUM_SLOTS; s++) begin
				sel = hc3_pkg::OPND_TBL[row_q][c][s];
				unique case (sel.src)
					hc3_pkg::SRC_D0: begin
						op_re[c][s] = $signed(q_item[hc3_pkg::FLD_D0]);
						op_im[c][s] = '0;
					end
					hc3_pkg::SRC_D1: begin
						op_re[c][s] = $signed(q_item[hc3_pkg::FLD_D1]);
						op_im[c][s] = '0;
					end
					hc3_pkg::SRC_D2: begin
						op_re[c][s] = $signed(q_item[hc3_pkg::FLD_D2]);
						op_im[c][s] = '0;
					end
					hc3_pkg::SRC_X: begin
						op_re[c][s] = $signed(q_item[hc3_pkg::FLD_XR]);
						op_im[c][s] = $signed(q_item[hc3_pkg::FLD_XI]);
					end
					hc3_pkg::SRC_Y: begin
						op_re[c][s] = $signed(q_item[hc3_pkg::FLD_YR]);
						op_im[c][s] = $signed(q_item[hc3_pkg::FLD_YI]);
					end
					hc3_pkg::SRC_Z: begin
						op_re[c][s] = $signed(q_item[hc3_pkg::FLD_ZR]);
						op_im[c][s] = $signed(q_item[hc3_pkg::FLD_ZI]);
					end
					default: begin
						op_re[c][s] = '0;
						op_im[c][s] = '0;
					end
				endcase
				// imaginary inputs are one bit narrower, negation cannot overflow
				if (sel.conj) begin
					op_im[c][s] = -op_im[c][s];
				end
			end
		end
	end

	// stage 1: eight real products per column
	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1 <= row_q;
			for (int c = 0; c < hc3_pkg::NUM_COLS; c++) begin
				prod_s1[c][0] <= op_re[c][0] * op_re[c][1];
				prod_s1[c][1] <= op_im[c][0] * op_im[c][1];
				prod_s1[c][2] <= op_re[c][2] * op_re[c][3];
				prod_s1[c][3] <= op_im[c][2] * op_im[c][3];
				prod_s1[c][4] <= op_re[c][0] * op_im[c][1];
				prod_s1[c][5] <= op_im[c][0] * op_re[c][1];
				prod_s1[c][6] <= op_re[c][2] * op_im[c][3];
				prod_s1[c][7] <= op_im[c][2] * op_re[c][3];
			end
		end
	end

	// stage 2: pair sums
	always_ff @(posedge clk) begin
		if (adv) begin
			row_s2 <= row_s1;
			for (int c = 0; c < hc3_pkg::NUM_COLS; c++) begin
				re_a_s2[c] <= PAIR_W'(prod_s1[c][0]) - PAIR_W'(prod_s1[c][1]);
				re_b_s2[c] <= PAIR_W'(prod_s1[c][2]) - PAIR_W'(prod_s1[c][3]);
				im_a_s2[c] <= PAIR_W'(prod_s1[c][4]) + PAIR_W'(prod_s1[c][5]);
				im_b_s2[c] <= PAIR_W'(prod_s1[c][6]) + PAIR_W'(prod_s1[c][7]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < hc3_pkg::NUM_COLS; c++) begin
			re_sum[c] = ACC_W'(re_a_s2[c]) - ACC_W'(re_b_s2[c]);
			im_sum[c] = ACC_W'(im_a_s2[c]) - ACC_W'(im_b_s2[c]);
		end
	end

	function automatic logic [hc3_pkg::OUT_W-1:0] sat64(input logic [ACC_W-1:0] v);
		logic [ACC_W-hc3_pkg::OUT_W:0] top;
		top = v[ACC_W-1:hc3_pkg::OUT_W-1];
		if ((&top) || !(|top)) begin
			return v[hc3_pkg::OUT_W-1:0];
		end
		return v[ACC_W-1] ? hc3_pkg::SAT_MIN : hc3_pkg::SAT_MAX;
	endfunction

	// stage 3: final sum and saturation, the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			row_s3 <= row_s2;
			for (int c = 0; c < hc3_pkg::NUM_COLS; c++) begin
				re_s3[c] <= sat64(re_sum[c]);
				im_s3[c] <= sat64(im_sum[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid = valid_s3;
	assign row_index = row_s3;
	assign res_re    = re_s3;
	assign res_im    = im_s3;
	assign last_row  = (row_s3 == hc3_pkg::LAST_ROW);

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_index <= hc3_pkg::LAST_ROW)
		else $error("row index out of range");

	a_diag_real: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (row_index != hc3_pkg::ROW_0 || res_im[0] == '0) &&
			(row_index != hc3_pkg::ROW_1 || res_im[1] == '0) &&
			(row_index != hc3_pkg::ROW_2 || res_im[2] == '0))
		else $error("diagonal cofactor has imaginary part");

	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> valid_s1 && row_s1 == hc3_pkg::LAST_ROW)
		else $error("item popped before its last row issued");

endmodule

### test/hermitian_cofactor_3x3_top_tb.sv
// ----------------------------------------------------------------------------
// hermitian_cofactor_3x3_top_tb: self-checking bench of the cofactor block
// Drives shifted hermitian 3x3 matrices through the valid/ready input,
// predicts the three saturated Q32.32 cofactor rows of each one with exact
// wide arithmetic, and checks every row taken from the output channel, under
// several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module hermitian_cofactor_3x3_top_tb;

	import hc3_pkg::*;

	localparam int DW         = DATA_WIDTH_DEF;
	localparam int ACC_W      = 2 * DW + 6;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_GAP    = 40;
	localparam int RAND_ITEMS = 90;

	localparam logic signed [DW-1:0] FIELD_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] FIELD_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] FIX_ONE   = 1 <<< (DW / 2);

	// one input item, named after the ports
	typedef struct {
		logic signed [DW-1:0] diag_a, diag_b, diag_c;
		logic signed [DW-1:0] ab_real, ab_imag, ac_real, ac_imag, bc_real, bc_imag;
		logic signed [DW-1:0] eigen_value;
	} matrix_item_t;

	// one cofactor row: real/imag of columns 0..2 in port order
	typedef struct {
		logic [ROW_W-1:0]         row;
		logic signed [OUT_W-1:0]  val [6];
		logic                     last;
	} cof_row_t;

	// one complex operand, one bit wider than the input so shifts and conjugates fit
	typedef struct {
		logic signed [DW:0] re, im;
	} cval_t;

	class cofactor_scoreboard;
		cof_row_t pending_rows [$];
		int       mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int pending();
			return pending_rows.size();
		endfunction

		function logic signed [ACC_W-1:0] wide_mul(input logic signed [DW:0] p, q);
			logic signed [ACC_W-1:0] wp, wq;
			wp = p;
			wq = q;
			return wp * wq;
		endfunction

		function logic signed [OUT_W-1:0] clamp(input logic signed [ACC_W-1:0] w);
			if (w[ACC_W-1:OUT_W-1] == {(ACC_W-OUT_W+1){w[ACC_W-1]}})
				return w[OUT_W-1:0];
			return w[ACC_W-1] ? SAT_MIN : SAT_MAX;
		endfunction

		function cval_t conj(input cval_t v);
			cval_t r;
			r.re = v.re;
			r.im = -v.im;
			return r;
		endfunction

		// entry = p1*q1 - p2*q2, summed exactly then clamped
		function void cofactor_entry(input cval_t p1, q1, p2, q2,
				output logic signed [OUT_W-1:0] re, im);
			logic signed [ACC_W-1:0] wr, wi;
			wr = wide_mul(p1.re, q1.re) - wide_mul(p1.im, q1.im)
				- wide_mul(p2.re, q2.re) + wide_mul(p2.im, q2.im);
			wi = wide_mul(p1.re, q1.im) + wide_mul(p1.im, q1.re)
				- wide_mul(p2.re, q2.im) - wide_mul(p2.im, q2.re);
			re = clamp(wr);
			im = clamp(wi);
		endfunction

		// predicts the three rows of one accepted matrix
		function void note_matrix(input matrix_item_t it);
			cval_t d0, d1, d2, x, y, z;
			cof_row_t r [3];
			d0.re = it.diag_a - it.eigen_value;
			d1.re = it.diag_b - it.eigen_value;
			d2.re = it.diag_c - it.eigen_value;
			d0.im = '0;
			d1.im = '0;
			d2.im = '0;
			x.re = it.ab_real;
			x.im = it.ab_imag;
			y.re = it.ac_real;
			y.im = it.ac_imag;
			z.re = it.bc_real;
			z.im = it.bc_imag;
			cofactor_entry(d1, d2, z, conj(z), r[0].val[0], r[0].val[1]);
			cofactor_entry(z, conj(y), conj(x), d2, r[0].val[2], r[0].val[3]);
			cofactor_entry(conj(z), conj(x), conj(y), d1, r[0].val[4], r[0].val[5]);
			cofactor_entry(y, conj(z), x, d2, r[1].val[0], r[1].val[1]);
			cofactor_entry(d0, d2, y, conj(y), r[1].val[2], r[1].val[3]);
			cofactor_entry(conj(y), x, conj(z), d0, r[1].val[4], r[1].val[5]);
			cofactor_entry(x, z, y, d1, r[2].val[0], r[2].val[1]);
			cofactor_entry(conj(x), y, z, d0, r[2].val[2], r[2].val[3]);
			cofactor_entry(d0, d1, x, conj(x), r[2].val[4], r[2].val[5]);
			r[0].row = ROW_0;
			r[1].row = ROW_1;
			r[2].row = ROW_2;
			for (int i = 0; i < NUM_ROWS; i++) begin
				r[i].last = (r[i].row == LAST_ROW);
				pending_rows.push_back(r[i]);
			end
		endfunction

		function void report(input string what, input logic [OUT_W-1:0] want, got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", what, want, got);
		endfunction

		function void check_row(input cof_row_t seen);
			cof_row_t want;
			string col_name [6];
			col_name = '{"col0_real", "col0_imag", "col1_real", "col1_imag",
				"col2_real", "col2_imag"};
			if (pending_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected row %0d with no matrix outstanding", seen.row);
				return;
			end
			want = pending_rows.pop_front();
			if (seen.row !== want.row)
				report("row_index", OUT_W'(want.row), OUT_W'(seen.row));
			if (seen.last !== want.last)
				report("last_row", OUT_W'(want.last), OUT_W'(seen.last));
			for (int i = 0; i < 6; i++)
				if (seen.val[i] !== want.val[i])
					report(col_name[i], want.val[i], seen.val[i]);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DW-1:0] diag_a = '0, diag_b = '0, diag_c = '0;
	logic signed [DW-1:0] ab_real = '0, ab_imag = '0, ac_real = '0, ac_imag = '0;
	logic signed [DW-1:0] bc_real = '0, bc_imag = '0, eigen_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ROW_W-1:0] row_index;
	logic signed [OUT_W-1:0] col0_real, col0_imag, col1_real, col1_imag;
	logic signed [OUT_W-1:0] col2_real, col2_imag;
	logic last_row;

	cofactor_scoreboard sb = new();

	// idling mix of the current phase, in percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	hermitian_cofactor_3x3_top #(
		.DATA_WIDTH(DW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.diag_a(diag_a),
		.diag_b(diag_b),
		.diag_c(diag_c),
		.ab_real(ab_real),
		.ab_imag(ab_imag),
		.ac_real(ac_real),
		.ac_imag(ac_imag),
		.bc_real(bc_real),
		.bc_imag(bc_imag),
		.eigen_value(eigen_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.row_index(row_index),
		.col0_real(col0_real),
		.col0_imag(col0_imag),
		.col1_real(col1_real),
		.col1_imag(col1_imag),
		.col2_real(col2_real),
		.col2_imag(col2_imag),
		.last_row(last_row)
	);

	always #4 clk = ~clk;

	// receiver: ready decided at the falling edge for the coming rising edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// every row taken by the receiver is checked against the oldest prediction
	always @(posedge clk) begin : row_monitor
		cof_row_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.row = row_index;
			seen.val[0] = col0_real;
			seen.val[1] = col0_imag;
			seen.val[2] = col1_real;
			seen.val[3] = col1_imag;
			seen.val[4] = col2_real;
			seen.val[5] = col2_imag;
			seen.last = last_row;
			sb.check_row(seen);
		end
	end

	// watchdog: too long without any item moving on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("hermitian_cofactor_3x3_top verification failed");
			$finish;
		end
	end

	function automatic matrix_item_t mk(input logic signed [DW-1:0] a, b, c,
			xr, xi, yr, yi, zr, zi, k);
		matrix_item_t it;
		it.diag_a = a;
		it.diag_b = b;
		it.diag_c = c;
		it.ab_real = xr;
		it.ab_imag = xi;
		it.ac_real = yr;
		it.ac_imag = yi;
		it.bc_real = zr;
		it.bc_imag = zi;
		it.eigen_value = k;
		return it;
	endfunction

	// one field value: full range, small around zero, or an edge value
	function automatic logic signed [DW-1:0] pick_field(input int flavor);
		logic signed [DW-1:0] v;
		v = $urandom;
		if (flavor == 1) begin
			v = $urandom_range(2097151);
			v = v - 1048576;
		end else if (flavor == 2) begin
			case ($urandom_range(5))
				0: v = FIELD_MAX;
				1: v = FIELD_MIN;
				2: v = '0;
				3: v = -1;
				4: v = 1;
				default: v = $urandom;
			endcase
		end
		return v;
	endfunction

	function automatic matrix_item_t random_matrix();
		int pick, flavor;
		pick = $urandom_range(99);
		flavor = (pick < 40) ? 0 : (pick < 75) ? 1 : 2;
		return mk(pick_field(flavor), pick_field(flavor), pick_field(flavor),
			pick_field(flavor), pick_field(flavor), pick_field(flavor),
			pick_field(flavor), pick_field(flavor), pick_field(flavor),
			pick_field(flavor));
	endfunction

	// offers one item after an idle gap and waits for it to be taken
	task automatic send_matrix(input matrix_item_t it);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		diag_a <= it.diag_a;
		diag_b <= it.diag_b;
		diag_c <= it.diag_c;
		ab_real <= it.ab_real;
		ab_imag <= it.ab_imag;
		ac_real <= it.ac_real;
		ac_imag <= it.ac_imag;
		bc_real <= it.bc_real;
		bc_imag <= it.bc_imag;
		eigen_value <= it.eigen_value;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_matrix(it);
	endtask

	// sender goes quiet until every predicted row has been seen
	task automatic drain_rows();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int send_mix [4];
		int recv_mix [4];
		send_mix = '{0, 50, 0, 6};
		recv_mix = '{0, 0, 50, 6};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed corners, no idling
		send_matrix(mk('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
		send_matrix(mk(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
			FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, '0));
		send_matrix(mk(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN,
			FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, '0));
		// widest positive shifted diagonal, diagonal cofactors clamp high
		send_matrix(mk(FIELD_MAX, FIELD_MAX, FIELD_MAX, '0, '0, '0, '0, '0, '0,
			FIELD_MIN));
		// widest negative shifted diagonal
		send_matrix(mk(FIELD_MIN, FIELD_MIN, FIELD_MIN, '0, '0, '0, '0, '0, '0,
			FIELD_MAX));
		send_matrix(mk(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MIN,
			FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, '0));
		// shift equal to the diagonal cancels it
		send_matrix(mk(FIX_ONE, FIX_ONE, FIX_ONE, '0, '0, '0, '0, '0, '0, FIX_ONE));
		// norm of z lands just below the 64-bit range
		send_matrix(mk('0, -1, 1, '0, '0, '0, '0, FIELD_MIN, FIELD_MIN, '0));
		// norm of z lands exactly on the lowest 64-bit value
		send_matrix(mk('0, '0, '0, '0, '0, '0, '0, FIELD_MIN, FIELD_MIN, '0));
		send_matrix(mk('0, '0, '0, FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX,
			FIELD_MAX, FIELD_MAX, FIELD_MAX));
		send_matrix(mk(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
			32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
			32'sh55555555, 32'shAAAAAAAA));
		send_matrix(mk(32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
			32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
			32'shAAAAAAAA, 32'sh55555555));
		// purely imaginary off-diagonal entries
		send_matrix(mk('0, '0, '0, '0, 3 * FIX_ONE, '0, -2 * FIX_ONE, '0, FIX_ONE, '0));
		send_matrix(mk(-1, -1, -1, 1, 1, 1, 1, 1, 1, -1));
		send_matrix(mk(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
			FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MIN));
		send_matrix(mk(FIX_ONE / 2, -FIX_ONE / 4, 3 * FIX_ONE, FIX_ONE / 8,
			-FIX_ONE / 8, FIX_ONE, -FIX_ONE, 2 * FIX_ONE, -FIX_ONE / 2, FIX_ONE / 2));

		// pause until every row is out before the random phases
		drain_rows();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_mix[ph];
			recv_stall_pct = recv_mix[ph];
			repeat (RAND_ITEMS)
				send_matrix(random_matrix());
			drain_rows();
		end

		// settle, then make sure nothing stray shows up
		repeat (12) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("hermitian_cofactor_3x3_top verification clean");
		else
			$display("hermitian_cofactor_3x3_top verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/hc3_pkg.sv
rtl/core/hc3_front.sv
rtl/core/hc3_back.sv
rtl/core/hermitian_cofactor_3x3_top.sv
test/hermitian_cofactor_3x3_top_tb.sv
